### hdl/dtot_pkg.sv
`timescale 1ns / 1ps

package dtot_pkg;

	// Section size bounds and descriptor cap (defaults for the top level)
	localparam int MIN_SECTION_BYTES_DEF = 14;
	localparam int MAX_SECTION_BYTES_DEF = 1024;
	localparam int MAX_DESCRIPTORS_DEF   = 32;

	// Field widths
	localparam int IDX_W    = 11;
	localparam int LEN_W    = 12;
	localparam int UTC_W    = 40;
	localparam int CNT_W    = 6;
	localparam int OFF_W    = 10;
	localparam int CRC_W    = 32;

	localparam logic [IDX_W-1:0] IDX_MAX   = '1;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	// Header byte positions
	localparam logic [IDX_W-1:0] POS_TABLE_ID  = 11'd0;
	localparam logic [IDX_W-1:0] POS_LEN_HI    = 11'd1;
	localparam logic [IDX_W-1:0] POS_LEN_LO    = 11'd2;
	localparam logic [IDX_W-1:0] POS_UTC_FIRST = 11'd3;
	localparam logic [IDX_W-1:0] POS_UTC_LAST  = 11'd7;
	localparam logic [IDX_W-1:0] POS_LOOP_HI   = 11'd8;
	localparam logic [IDX_W-1:0] POS_LOOP_LO   = 11'd9;
	localparam logic [IDX_W-1:0] POS_LOOP_BASE = 11'd10;

	// Result codes
	localparam logic KIND_DESC    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_CRC  = 2'd1;
	localparam logic [1:0] STATUS_SIZE = 2'd2;

	// MPEG-2 CRC-32
	localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic advance;
		logic restart;
	} crc_ctrl_t;

	typedef struct packed {
		logic             residue_bad;
		logic [CRC_W-1:0] tail_word;
	} crc_stat_t;

	// One byte of the CRC, MSB first, no reflection
	function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc_in,
			input logic [7:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### hdl/dvb_tot_section_parser.sv
`timescale 1ns / 1ps
// Each accepted byte's result is registered straight into the output register.
// Throughput: one byte per cycle unless a held result drops in_ready; header, descriptor
// walk and byte-wide CRC-32 all finish between the parser state and the output register.
// in_ready drops only while a result is held and out_ready is low.
// Reset (arst_n low) clears the parser state, loads the CRC with all ones and
// empties the output register; the final byte also clears state and reloads the CRC.

module dvb_tot_section_parser #(
	parameter int MIN_SECTION_BYTES = dtot_pkg::MIN_SECTION_BYTES_DEF,
	parameter int MAX_SECTION_BYTES = dtot_pkg::MAX_SECTION_BYTES_DEF,
	parameter int MAX_DESCRIPTORS   = dtot_pkg::MAX_DESCRIPTORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          final_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          record_kind,
	output logic [7:0]                    desc_tag,
	output logic [7:0]                    desc_length,
	output logic [dtot_pkg::OFF_W-1:0]    desc_offset,
	output logic [7:0]                    table_ident,
	output logic                          syntax_flag,
	output logic [dtot_pkg::LEN_W-1:0]    sect_length,
	output logic [dtot_pkg::UTC_W-1:0]    utc_stamp,
	output logic [dtot_pkg::LEN_W-1:0]    loop_length,
	output logic [dtot_pkg::CNT_W-1:0]    desc_total,
	output logic [1:0]                    parse_status,
	output logic [dtot_pkg::CRC_W-1:0]    crc_received
);

	localparam int IW = dtot_pkg::IDX_W;
	localparam int LW = dtot_pkg::LEN_W;
	localparam int CW = dtot_pkg::CNT_W;

	// Parser state
	logic [IW-1:0]              byte_idx_q;
	logic [7:0]                 table_id_q;
	logic                       syntax_q;
	logic [LW-1:0]              sect_len_q;
	logic [LW-1:0]              loop_len_q;
	logic [dtot_pkg::UTC_W-1:0] utc_q;
	logic [LW-1:0]              loop_rem_q;
	logic [IW-1:0]              next_pos_q;
	logic [7:0]                 pend_tag_q;
	logic [CW-1:0]              desc_cnt_q;

	logic [7:0]                 table_id_d;
	logic                       syntax_d;
	logic [LW-1:0]              sect_len_d;
	logic [LW-1:0]              loop_len_d;
	logic [dtot_pkg::UTC_W-1:0] utc_d;
	logic [LW-1:0]              loop_rem_d;
	logic [IW-1:0]              next_pos_d;
	logic [7:0]                 pend_tag_d;
	logic [CW-1:0]              desc_cnt_d;

	// Output register
	logic                       out_valid_q;
	logic                       kind_q;
	logic [7:0]                 tag_q;
	logic [7:0]                 dlen_q;
	logic [dtot_pkg::OFF_W-1:0] off_q;
	logic [7:0]                 tid_q;
	logic                       syn_q;
	logic [LW-1:0]              slen_q;
	logic [dtot_pkg::UTC_W-1:0] utc_out_q;
	logic [LW-1:0]              llen_q;
	logic [CW-1:0]              total_q;
	logic [1:0]                 status_q;
	logic [dtot_pkg::CRC_W-1:0] crc_rx_q;

	logic                       accept;
	logic                       emit_desc;
	logic                       size_bad;
	logic [IW:0]                sect_size;
	logic [8:0]                 move;
	logic [IW:0]                next_sum;
	logic                       walk_on;
	dtot_pkg::crc_ctrl_t        crc_ctrl;
	dtot_pkg::crc_stat_t        crc_stat;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign crc_ctrl.advance = accept;
	assign crc_ctrl.restart = final_byte;

	dtot_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (crc_ctrl),
		.data_byte (data_byte),
		.stat      (crc_stat)
	);

	assign move      = {1'b0, data_byte} + 9'd2;
	assign next_sum  = {1'b0, next_pos_q} + {{(IW-8){1'b0}}, move};
	assign sect_size = {1'b0, byte_idx_q} + {{IW{1'b0}}, 1'b1};
	assign size_bad  = ({1'b0, sect_size} < (IW+2)'(MIN_SECTION_BYTES)) ||
			({1'b0, sect_size} > (IW+2)'(MAX_SECTION_BYTES));
	assign walk_on   = (loop_rem_q >= LW'(2)) &&
			({1'b0, desc_cnt_q} < (CW+1)'(MAX_DESCRIPTORS)) &&
			(desc_cnt_q != dtot_pkg::CNT_MAX);

	always_comb begin
		table_id_d = table_id_q;
		syntax_d   = syntax_q;
		sect_len_d = sect_len_q;
		loop_len_d = loop_len_q;
		utc_d      = utc_q;
		loop_rem_d = loop_rem_q;
		next_pos_d = next_pos_q;
		pend_tag_d = pend_tag_q;
		desc_cnt_d = desc_cnt_q;
		emit_desc  = 1'b0;
		// Past the saturated index only the CRC and tail advance
		if (byte_idx_q != dtot_pkg::IDX_MAX) begin
			if (byte_idx_q == dtot_pkg::POS_TABLE_ID) begin
				table_id_d = data_byte;
			end else if (byte_idx_q == dtot_pkg::POS_LEN_HI) begin
				syntax_d   = data_byte[7];
				sect_len_d = {data_byte[3:0], 8'h00};
			end else if (byte_idx_q == dtot_pkg::POS_LEN_LO) begin
				sect_len_d = {sect_len_q[LW-1:8], data_byte};
			end else if (byte_idx_q >= dtot_pkg::POS_UTC_FIRST &&
					byte_idx_q <= dtot_pkg::POS_UTC_LAST) begin
				utc_d = {utc_q[dtot_pkg::UTC_W-9:0], data_byte};
			end else if (byte_idx_q == dtot_pkg::POS_LOOP_HI) begin
				loop_len_d = {data_byte[3:0], 8'h00};
			end else if (byte_idx_q == dtot_pkg::POS_LOOP_LO) begin
				loop_len_d = {loop_len_q[LW-1:8], data_byte};
				loop_rem_d = {loop_len_q[LW-1:8], data_byte};
				next_pos_d = dtot_pkg::POS_LOOP_BASE;
			end else if (walk_on) begin
				if (byte_idx_q == next_pos_q) begin
					pend_tag_d = data_byte;
				end else if ({1'b0, byte_idx_q} == {1'b0, next_pos_q} + {{IW{1'b0}}, 1'b1}
						&& !final_byte) begin
					emit_desc  = 1'b1;
					desc_cnt_d = desc_cnt_q + CW'(1);
					if ({{(LW-9){1'b0}}, move} > loop_rem_q) begin
						loop_rem_d = '0;
					end else begin
						loop_rem_d = loop_rem_q - {{(LW-9){1'b0}}, move};
					end
					if (next_sum > {1'b0, dtot_pkg::IDX_MAX}) begin
						next_pos_d = dtot_pkg::IDX_MAX;
					end else begin
						next_pos_d = next_sum[IW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			table_id_q <= '0;
			syntax_q   <= 1'b0;
			sect_len_q <= '0;
			loop_len_q <= '0;
			utc_q      <= '0;
			loop_rem_q <= '0;
			next_pos_q <= '0;
			pend_tag_q <= '0;
			desc_cnt_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				// Section ends: return to the idle header state
				byte_idx_q <= '0;
				table_id_q <= '0;
				syntax_q   <= 1'b0;
				sect_len_q <= '0;
				loop_len_q <= '0;
				utc_q      <= '0;
				loop_rem_q <= '0;
				next_pos_q <= '0;
				pend_tag_q <= '0;
				desc_cnt_q <= '0;
			end else begin
				if (byte_idx_q != dtot_pkg::IDX_MAX) begin
					byte_idx_q <= byte_idx_q + IW'(1);
				end
				table_id_q <= table_id_d;
				syntax_q   <= syntax_d;
				sect_len_q <= sect_len_d;
				loop_len_q <= loop_len_d;
				utc_q      <= utc_d;
				loop_rem_q <= loop_rem_d;
				next_pos_q <= next_pos_d;
				pend_tag_q <= pend_tag_d;
				desc_cnt_q <= desc_cnt_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (final_byte || emit_desc)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; unused fields of each record kind read as zero
	always_ff @(posedge clk) begin
		if (accept && (final_byte || emit_desc)) begin
			kind_q    <= final_byte ? dtot_pkg::KIND_SUMMARY : dtot_pkg::KIND_DESC;
			tag_q     <= final_byte ? 8'h00 : pend_tag_q;
			dlen_q    <= final_byte ? 8'h00 : data_byte;
			off_q     <= final_byte ? '0 : next_pos_q[dtot_pkg::OFF_W-1:0];
			if (final_byte && !size_bad) begin
				tid_q     <= table_id_d;
				syn_q     <= syntax_d;
				slen_q    <= sect_len_d;
				utc_out_q <= utc_d;
				llen_q    <= loop_len_d;
				total_q   <= desc_cnt_d;
				status_q  <= crc_stat.residue_bad ? dtot_pkg::STATUS_CRC :
						dtot_pkg::STATUS_OK;
				crc_rx_q  <= crc_stat.tail_word;
			end else begin
				tid_q     <= '0;
				syn_q     <= 1'b0;
				slen_q    <= '0;
				utc_out_q <= '0;
				llen_q    <= '0;
				total_q   <= '0;
				status_q  <= final_byte ? dtot_pkg::STATUS_SIZE : dtot_pkg::STATUS_OK;
				crc_rx_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign record_kind  = kind_q;
	assign desc_tag     = tag_q;
	assign desc_length  = dlen_q;
	assign desc_offset  = off_q;
	assign table_ident  = tid_q;
	assign syntax_flag  = syn_q;
	assign sect_length  = slen_q;
	assign utc_stamp    = utc_out_q;
	assign loop_length  = llen_q;
	assign desc_total   = total_q;
	assign parse_status = status_q;
	assign crc_received = crc_rx_q;

`ifndef NO_ASSERTIONS
	a_final_gives_summary: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_byte |=> out_valid && (record_kind == dtot_pkg::KIND_SUMMARY))
		else $error("final byte did not produce a section summary");

	a_final_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_byte |=> (byte_idx_q == '0) && (desc_cnt_q == '0) &&
			(loop_rem_q == '0))
		else $error("parser state not cleared after final byte");

	a_size_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (record_kind == dtot_pkg::KIND_SUMMARY) &&
			(parse_status == dtot_pkg::STATUS_SIZE)
		|-> (desc_total == '0) && (crc_received == '0) && (loop_length == '0))
		else $error("size error summary carries field data");

	a_desc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit_desc |=> ({1'b0, desc_cnt_q} <= (CW+1)'(MAX_DESCRIPTORS)))
		else $error("descriptor count exceeds the cap");

	a_stall_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !accept)
		else $error("byte accepted while a result is stalled");
`endif

endmodule

### hdl/dtot_crc.sv
`timescale 1ns / 1ps

module dtot_crc (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dtot_pkg::crc_ctrl_t     ctrl,
	input  logic [7:0]              data_byte,
	output dtot_pkg::crc_stat_t     stat
);

	logic [dtot_pkg::CRC_W-1:0] crc_q;
	logic [dtot_pkg::CRC_W-1:0] tail_q;
	logic [dtot_pkg::CRC_W-1:0] crc_nxt;
	logic [dtot_pkg::CRC_W-1:0] tail_nxt;

	assign crc_nxt  = dtot_pkg::crc32_byte(crc_q, data_byte);
	assign tail_nxt = {tail_q[dtot_pkg::CRC_W-9:0], data_byte};

	// Status reflects the byte being accepted now
	assign stat.residue_bad = (crc_nxt != '0);
	assign stat.tail_word   = tail_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= dtot_pkg::CRC_INIT;
			tail_q <= '0;
		end else if (ctrl.advance) begin
			if (ctrl.restart) begin
				crc_q  <= dtot_pkg::CRC_INIT;
				tail_q <= '0;
			end else begin
				crc_q  <= crc_nxt;
				tail_q <= tail_nxt;
			end
		end
	end

endmodule
